>>> hdl/mbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbb_pkg
// Shared widths, codes, the per-pixel step record and the size clamp.
// ----------------------------------------------------------------------------
package mbb_pkg;

    localparam int DIM_W     = 11;          // display and image sizes
    localparam int POS_W     = 10;          // placement offsets
    localparam int PIX_W     = DIM_W + 1;   // placed pixel coordinate
    localparam int IDX_W     = 2 * DIM_W;   // pixel bit index in the store
    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = 16;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [OP_W-1:0] OP_BLIT  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_X         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd5;

    // Outcome of one source pixel at the current position.
    typedef struct packed {
        logic             consumed;  // image fully consumed at the current position
        logic             skip;      // pixel falls past the image end
        logic             draw;      // pixel lands inside the display
        logic [DIM_W-1:0] col_next;
        logic [DIM_W-1:0] row_next;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
    } pix_step_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int max_dim);
        logic [DIM_W-1:0] r;
        r = v;
        if (int'(v) > max_dim)
            r = DIM_W'(max_dim);
        return r;
    endfunction

endpackage

>>> hdl/mbb_frame_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbb_frame_ram
// Byte-wide framebuffer store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mbb_frame_ram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Hold the last read word while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

>>> hdl/mbb_pixel_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbb_pixel_step
// Position advance and clipping for one source pixel.
// ----------------------------------------------------------------------------
module mbb_pixel_step (
    input  logic [mbb_pkg::DIM_W-1:0] col,
    input  logic [mbb_pkg::DIM_W-1:0] row,
    input  logic [mbb_pkg::DIM_W-1:0] img_w,
    input  logic [mbb_pkg::DIM_W-1:0] img_h,
    input  logic [mbb_pkg::DIM_W-1:0] disp_w,
    input  logic [mbb_pkg::DIM_W-1:0] disp_h,
    input  logic [mbb_pkg::POS_W-1:0] dest_x,
    input  logic [mbb_pkg::POS_W-1:0] dest_y,
    output mbb_pkg::pix_step_t        step
);
    import mbb_pkg::*;

    logic             consumed;
    logic             wrap;
    logic [DIM_W-1:0] c1;
    logic [DIM_W-1:0] r1;
    logic [DIM_W-1:0] c2;

    assign consumed = (img_w == '0) || (img_h == '0) || (row >= img_h);
    assign wrap     = (col >= img_w);
    assign c1       = wrap ? '0 : col;
    assign r1       = wrap ? row + DIM_W'(1) : row;
    assign c2       = c1 + DIM_W'(1);

    always_comb
    begin
        step.consumed = consumed;
        step.px       = PIX_W'(dest_x) + PIX_W'(c1);
        step.py       = PIX_W'(dest_y) + PIX_W'(r1);
        step.skip     = 1'b0;
        step.col_next = c2;
        step.row_next = r1;
        if (consumed)
        begin
            step.skip     = 1'b1;
            step.col_next = col;
            step.row_next = row;
        end
        else if (wrap && (r1 >= img_h))
        begin
            step.skip     = 1'b1;
            step.col_next = '0;
            step.row_next = r1;
        end
        else if (c2 >= img_w)
        begin
            step.col_next = '0;
            step.row_next = r1 + DIM_W'(1);
        end
        step.draw = !step.skip && (disp_w != '0) && (disp_h != '0)
                    && (step.px < PIX_W'(disp_w)) && (step.py < PIX_W'(disp_h));
    end

endmodule

>>> hdl/mono_bitmap_blit_clipped.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_bitmap_blit_clipped
// 1bpp framebuffer with a clipped bit blit and byte read/write access.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid/in_ready) carry op, first, source_byte, address.
//   A blit beat (op 0) draws eight source pixels MSB first at the current
//   image position; first restarts the position at the image origin. A set
//   source bit paints black (clears the store bit), a clear bit paints white.
//   Op 1 reads a store byte, op 2 writes one, op 3 does nothing.
//   Every input beat yields exactly one output beat (out_valid/out_ready)
//   with read_data, blit_done and dropped.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Timing:
//   One item at a time; in_ready is high only while the sequencer is idle.
//   Reads pass S_RDA, writes S_WRA, op 3 neither, then S_FIN loads the result.
//   A blit sends each pixel through S_POS (skipped or clipped ones end there),
//   the shared multiply/read/modify/write path S_MUL, S_RDP (past-store ends)
//   and S_WRP. The next beat is taken the cycle after the result loads.
// Reset and stall:
//   Reset clears the configuration, the image position and the control
//   state; the store contents are undefined until written. A result waits in
//   the output register; the next beat is still accepted, but its result is
//   held in the finish state until the output register frees.
// ----------------------------------------------------------------------------
module mono_bitmap_blit_clipped #(
    parameter int FB_BYTES = 65536,
    parameter int MAX_DIM  = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mbb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mbb_pkg::DIM_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mbb_pkg::OP_W-1:0]      op,
    input  logic                          first,
    input  logic [mbb_pkg::BYTE_W-1:0]    source_byte,
    input  logic [mbb_pkg::ADDR_W-1:0]    address,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mbb_pkg::BYTE_W-1:0]    read_data,
    output logic                          blit_done,
    output logic                          dropped
);
    import mbb_pkg::*;

    localparam int FB_AW   = $clog2(FB_BYTES);
    localparam int BIDX_W  = IDX_W - 3;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POS  = 3'd1;   // advance position, clip
    localparam logic [2:0] S_MUL  = 3'd2;   // row offset multiply
    localparam logic [2:0] S_RDP  = 3'd3;   // pixel byte read
    localparam logic [2:0] S_WRP  = 3'd4;   // pixel byte write back
    localparam logic [2:0] S_RDA  = 3'd5;   // host byte read
    localparam logic [2:0] S_WRA  = 3'd6;   // host byte write
    localparam logic [2:0] S_FIN  = 3'd7;   // hand result to output register

    // Configuration
    logic [DIM_W-1:0] disp_w_reg, disp_h_reg, img_w_reg, img_h_reg;
    logic [POS_W-1:0] dest_x_reg, dest_y_reg;
    logic [DIM_W-1:0] dw, dh, iw, ih;

    // Control
    logic [2:0]       state_reg, state_next;
    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic [2:0]       bit_reg, bit_next;
    logic             lost_reg, lost_next;
    logic             out_valid_reg, out_valid_next;

    // Payload
    logic [OP_W-1:0]   op_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [PIX_W-1:0]  px_reg, py_reg;
    logic [IDX_W-1:0]  prod_reg;
    logic [FB_AW-1:0]  byte_reg;
    logic [2:0]        mask_sel_reg;
    logic              rd_ok_reg;
    logic [BYTE_W-1:0] read_data_reg;
    logic              blit_done_reg, dropped_reg;

    pix_step_t         step;
    logic              accept;
    logic              can_load;
    logic              addr_in_range;
    logic              pix_in_range;
    logic [IDX_W-1:0]  pix_idx;
    logic [BIDX_W-1:0] pix_byte;
    logic [BYTE_W-1:0] mask;
    logic [BYTE_W-1:0] modified;
    logic              black;

    logic              ram_we, ram_re;
    logic [FB_AW-1:0]  ram_waddr, ram_raddr;
    logic [BYTE_W-1:0] ram_wdata, ram_rdata;

    assign dw = clamp_dim(disp_w_reg, MAX_DIM);
    assign dh = clamp_dim(disp_h_reg, MAX_DIM);
    assign iw = clamp_dim(img_w_reg, MAX_DIM);
    assign ih = clamp_dim(img_h_reg, MAX_DIM);

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign can_load  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign blit_done = blit_done_reg;
    assign dropped   = dropped_reg;

    mbb_pixel_step u_step (
        .col    (col_reg),
        .row    (row_reg),
        .img_w  (iw),
        .img_h  (ih),
        .disp_w (dw),
        .disp_h (dh),
        .dest_x (dest_x_reg),
        .dest_y (dest_y_reg),
        .step   (step)
    );

    // Store addressing: pixel bit index = py*width + px, byte = index/8.
    assign pix_idx       = prod_reg + IDX_W'(px_reg);
    assign pix_byte      = pix_idx[IDX_W-1:3];
    assign pix_in_range  = 32'(pix_byte) < FB_BYTES;
    assign addr_in_range = 32'(addr_reg) < FB_BYTES;

    assign black    = data_reg[bit_reg];
    assign mask     = 8'h80 >> mask_sel_reg;
    assign modified = black ? (ram_rdata & ~mask) : (ram_rdata | mask);

    assign ram_re    = ((state_reg == S_RDP) && pix_in_range)
                       || ((state_reg == S_RDA) && addr_in_range);
    assign ram_raddr = (state_reg == S_RDA) ? FB_AW'(addr_reg) : FB_AW'(pix_byte);
    assign ram_we    = (state_reg == S_WRP)
                       || ((state_reg == S_WRA) && addr_in_range);
    assign ram_waddr = (state_reg == S_WRA) ? FB_AW'(addr_reg) : byte_reg;
    assign ram_wdata = (state_reg == S_WRA) ? data_reg : modified;

    mbb_frame_ram #(
        .DEPTH (FB_BYTES),
        .AW    (FB_AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        bit_next       = bit_reg;
        lost_next      = lost_reg;
        out_valid_next = out_valid_reg;

        // Drop the result once the receiver takes it.
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    lost_next = 1'b0;
                    bit_next  = 3'd7;
                    unique case (op)
                        OP_BLIT:
                        begin
                            state_next = S_POS;
                            if (first)
                            begin
                                col_next = '0;
                                row_next = '0;
                            end
                        end
                        OP_READ:  state_next = S_RDA;
                        OP_WRITE: state_next = S_WRA;
                        default:  state_next = S_FIN;
                    endcase
                end
            end
            S_POS:
            begin
                col_next = step.col_next;
                row_next = step.row_next;
                if (step.draw)
                    state_next = S_MUL;
                else if (bit_reg == 3'd0)
                    state_next = S_FIN;
                else
                    bit_next = bit_reg - 3'd1;
            end
            S_MUL:
                state_next = S_RDP;
            S_RDP:
            begin
                if (pix_in_range)
                    state_next = S_WRP;
                else
                begin
                    lost_next = 1'b1;
                    if (bit_reg == 3'd0)
                        state_next = S_FIN;
                    else
                    begin
                        bit_next   = bit_reg - 3'd1;
                        state_next = S_POS;
                    end
                end
            end
            S_WRP:
            begin
                if (bit_reg == 3'd0)
                    state_next = S_FIN;
                else
                begin
                    bit_next   = bit_reg - 3'd1;
                    state_next = S_POS;
                end
            end
            S_RDA:
                state_next = S_FIN;
            S_WRA:
            begin
                if (!addr_in_range)
                    lost_next = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // Hold here until the output register is free.
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            bit_reg       <= '0;
            lost_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            bit_reg       <= bit_next;
            lost_reg      <= lost_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_w_reg <= '0;
            disp_h_reg <= '0;
            dest_x_reg <= '0;
            dest_y_reg <= '0;
            img_w_reg  <= '0;
            img_h_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DISPLAY_WIDTH:  disp_w_reg <= cfg_data;
                CFG_DISPLAY_HEIGHT: disp_h_reg <= cfg_data;
                CFG_DEST_X:         dest_x_reg <= cfg_data[POS_W-1:0];
                CFG_DEST_Y:         dest_y_reg <= cfg_data[POS_W-1:0];
                CFG_IMAGE_WIDTH:    img_w_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT:   img_h_reg  <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op;
            data_reg <= source_byte;
            addr_reg <= address;
        end
        if (state_reg == S_POS)
        begin
            px_reg <= step.px;
            py_reg <= step.py;
        end
        // Row offset; a drawn pixel has py below the display height.
        if (state_reg == S_MUL)
            prod_reg <= IDX_W'(py_reg * dw);
        if (state_reg == S_RDP)
        begin
            byte_reg     <= FB_AW'(pix_byte);
            mask_sel_reg <= pix_idx[2:0];
        end
        if (state_reg == S_RDA)
            rd_ok_reg <= addr_in_range;
        if ((state_reg == S_FIN) && can_load)
        begin
            read_data_reg <= ((op_reg == OP_READ) && rd_ok_reg) ? ram_rdata : '0;
            blit_done_reg <= step.consumed;
            dropped_reg   <= lost_reg;
        end
    end

`ifndef ASSERT_OFF
    // A pixel write-back always follows its read.
    a_wrp_after_rdp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRP) |-> ($past(state_reg) == S_RDP))
        else $error("pixel write-back without preceding read");

    // A host write past the store is flagged.
    a_wra_flag: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_WRA) && !addr_in_range) |=> lost_reg)
        else $error("out-of-range host write not flagged");

    // An accepted beat leaves the idle state.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted beat did not start the sequencer");

    // Finishing with a free output register presents the result.
    a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FIN) && !out_valid_reg) |=> out_valid_reg)
        else $error("result not presented after finish");
`endif

endmodule
